// ===== design/srp_pkg.sv =====
// Shared types, constants and functions for the snapshot record parser.
`default_nettype none
package srp_pkg;

    localparam logic [63:0] CRC_POLY_REFL = 64'h95AC9329AC4BC9B5;
    localparam logic [4:0]  MIN_TOTAL     = 5'd17;
    localparam int          QDEPTH        = 4;
    localparam int          QPTR_W        = $clog2(QDEPTH);

    localparam logic [7:0] OP_AUX    = 8'hFA;
    localparam logic [7:0] OP_RESIZE = 8'hFB;
    localparam logic [7:0] OP_EXPIRE = 8'hFC;
    localparam logic [7:0] OP_SELECT = 8'hFE;
    localparam logic [7:0] OP_EOF    = 8'hFF;
    localparam logic [7:0] TYPE_STR  = 8'h00;
    localparam logic [7:0] LEN_MASK  = 8'hC0;
    localparam logic [7:0] LEN_6BIT  = 8'h00;
    localparam logic [7:0] LEN_14BIT = 8'h40;
    localparam logic [7:0] LEN_32BIT = 8'h80;
    localparam logic [7:0] LEN_64BIT = 8'h81;
    localparam logic [7:0] LEN_LOW   = 8'h3F;

    localparam logic [2:0] EV_START = 3'd0;
    localparam logic [2:0] EV_KEY   = 3'd1;
    localparam logic [2:0] EV_VALUE = 3'd2;
    localparam logic [2:0] EV_END   = 3'd3;
    localparam logic [2:0] EV_FINAL = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_CRC_BAD = 2'd2;
    localparam logic [1:0] ST_FORMAT  = 2'd3;

    // Item passed from the front end to the parser.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        is_final;
        logic        too_short;
        logic        crc_bad;
        logic [63:0] window;
    } srp_token_t;

    function automatic logic [7:0] srp_magic(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'h52;
            4'd1:    m = 8'h45;
            4'd2:    m = 8'h44;
            4'd3:    m = 8'h49;
            4'd4:    m = 8'h53;
            4'd5:    m = 8'h30;
            4'd6:    m = 8'h30;
            4'd7:    m = 8'h30;
            4'd8:    m = 8'h36;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] srp_crc_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY_REFL : 64'd0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/srp_front.sv =====
// Front end: delay window, running CRC and byte count; pushes parser items.
`default_nettype none
module srp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire logic               final_byte,
    output srp_pkg::srp_token_t     token,
    output logic                    push
);
    import srp_pkg::*;

    logic [7:0]  win_reg [8];
    logic [7:0]  win_next [8];
    logic [3:0]  fill_reg, fill_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] crc_reg, crc_next;
    logic [63:0] stored;
    logic        full;

    always_comb
    begin
        full = (fill_reg >= 4'd8);
        for (int i = 0; i < 8; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (full)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[7] = in_byte;
            fill_next   = fill_reg;
            crc_next    = srp_crc_byte(crc_reg, win_reg[0]);
        end
        else
        begin
            win_next[fill_reg[2:0]] = in_byte;
            fill_next = fill_reg + 4'd1;
            crc_next  = crc_reg;
        end
        cnt_next = (cnt_reg < MIN_TOTAL) ? cnt_reg + 5'd1 : cnt_reg;
        stored = {win_next[7], win_next[6], win_next[5], win_next[4],
                  win_next[3], win_next[2], win_next[1], win_next[0]};
        token.has_byte  = full;
        token.data_byte = win_reg[0];
        token.is_final  = final_byte;
        token.too_short = (cnt_next < MIN_TOTAL);
        token.crc_bad   = (crc_next != stored);
        token.window    = stored;
        push = accept && (full || final_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            fill_reg <= 4'd0;
            cnt_reg  <= 5'd0;
            crc_reg  <= 64'd0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    win_reg[i] <= 8'd0;
                end
                fill_reg <= 4'd0;
                cnt_reg  <= 5'd0;
                crc_reg  <= 64'd0;
            end
            else
            begin
                win_reg  <= win_next;
                fill_reg <= fill_next;
                cnt_reg  <= cnt_next;
                crc_reg  <= crc_next;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/srp_queue.sv =====
// Short queue of parser items between the front end and the parser.
`default_nettype none
module srp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire srp_pkg::srp_token_t push_token,
    input  wire logic                pop,
    output srp_pkg::srp_token_t      head,
    output logic                     not_empty,
    output logic                     not_full
);
    import srp_pkg::*;

    srp_token_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_reg, rd_reg;
    logic [QPTR_W:0]       cnt_reg;

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != (QPTR_W + 1)'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/srp_back.sv =====
// Back end: record parser, checksum drain and registered event output.
`default_nettype none
module srp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srp_pkg::srp_token_t head,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               event_kind,
    output logic [7:0]               out_byte,
    output logic                     has_expiry,
    output logic [63:0]              expiry_ms,
    output logic [1:0]               status,
    output logic                     last_result
);
    import srp_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER, PH_OP, PH_EXPIRY, PH_TYPE, PH_AUXK_LEN, PH_AUXV_LEN,
        PH_SEL_LEN, PH_RSZ1_LEN, PH_RSZ2_LEN, PH_KEY_LEN, PH_VAL_LEN,
        PH_AUXK_STR, PH_AUXV_STR, PH_KEY_STR, PH_VAL_STR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_reg, hdr_next;
    logic [63:0] lacc_reg, lacc_next;
    logic [3:0]  lleft_reg, lleft_next;
    logic [63:0] sleft_reg, sleft_next;
    logic [63:0] exp_reg, exp_next;
    logic        expp_reg, expp_next;
    logic        fmt_reg, fmt_next;
    logic        eof_reg, eof_next;
    logic        pend_reg, pend_next;
    logic        drn_reg, drn_next;
    logic [3:0]  didx_reg, didx_next;
    logic [63:0] dwin_reg, dwin_next;
    logic        dshort_reg, dshort_next;
    logic        dcrc_reg, dcrc_next;

    logic        ov_reg, ov_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  ob_reg, ob_next;
    logic        hx_reg, hx_next;
    logic [63:0] em_reg, em_next;
    logic [1:0]  st_reg, st_next;
    logic        last_reg, last_next;

    logic        step, p_en, mid, ld_en, fin_fmt;
    logic [7:0]  b;
    logic [63:0] ld_len;

    assign out_valid   = ov_reg;
    assign event_kind  = kind_reg;
    assign out_byte    = ob_reg;
    assign has_expiry  = hx_reg;
    assign expiry_ms   = em_reg;
    assign status      = st_reg;
    assign last_result = last_reg;

    always_comb
    begin
        phase_next = phase_reg; hdr_next = hdr_reg; lacc_next = lacc_reg;
        lleft_next = lleft_reg; sleft_next = sleft_reg; exp_next = exp_reg;
        expp_next = expp_reg; fmt_next = fmt_reg; eof_next = eof_reg;
        pend_next = pend_reg; drn_next = drn_reg; didx_next = didx_reg;
        dwin_next = dwin_reg; dshort_next = dshort_reg; dcrc_next = dcrc_reg;
        ov_next = ov_reg; kind_next = kind_reg; ob_next = 8'd0; hx_next = 1'b0;
        em_next = 64'd0; st_next = ST_OK; last_next = 1'b0;
        pop = 1'b0; p_en = 1'b0; b = 8'd0; ld_en = 1'b0; ld_len = 64'd0;
        fin_fmt = 1'b0;
        step = !ov_reg || out_ready;
        mid  = !fmt_reg && !eof_reg && phase_reg != PH_OP && phase_reg != PH_HEADER;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end

        if (step)
        begin
            if (pend_reg)
            begin
                ov_next = 1'b1; kind_next = EV_END; pend_next = 1'b0;
            end
            else if (drn_reg)
            begin
                if (!dshort_reg && !didx_reg[3] && mid)
                begin
                    p_en = 1'b1;
                    b = dwin_reg[{didx_reg[2:0], 3'b000} +: 8];
                    didx_next = didx_reg + 4'd1;
                end
                else
                begin
                    fin_fmt = fmt_reg || mid;
                    ov_next = 1'b1; kind_next = EV_FINAL; last_next = 1'b1;
                    st_next = dshort_reg ? ST_SHORT : dcrc_reg ? ST_CRC_BAD :
                              fin_fmt ? ST_FORMAT : ST_OK;
                    drn_next = 1'b0; phase_next = PH_HEADER; hdr_next = 4'd0;
                    lacc_next = 64'd0; lleft_next = 4'd0; sleft_next = 64'd0;
                    exp_next = 64'd0; expp_next = 1'b0; fmt_next = 1'b0;
                    eof_next = 1'b0;
                end
            end
            else if (head_valid)
            begin
                pop = 1'b1;
                p_en = head.has_byte;
                b = head.data_byte;
                if (head.is_final)
                begin
                    drn_next = 1'b1; didx_next = 4'd0; dwin_next = head.window;
                    dshort_next = head.too_short; dcrc_next = head.crc_bad;
                end
            end
        end

        if (p_en && !fmt_reg && !eof_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (b != srp_magic(hdr_reg))
                    begin
                        fmt_next = 1'b1;
                    end
                    else
                    begin
                        hdr_next = hdr_reg + 4'd1;
                        if (hdr_reg == 4'd8)
                        begin
                            phase_next = PH_OP;
                        end
                    end
                end
                PH_OP:
                begin
                    if (b == OP_AUX) phase_next = PH_AUXK_LEN;
                    else if (b == OP_SELECT) phase_next = PH_SEL_LEN;
                    else if (b == OP_RESIZE) phase_next = PH_RSZ1_LEN;
                    else if (b == OP_EOF) eof_next = 1'b1;
                    else if (b == OP_EXPIRE)
                    begin
                        expp_next = 1'b1; exp_next = 64'd0; lleft_next = 4'd8;
                        phase_next = PH_EXPIRY;
                    end
                    else if (b == TYPE_STR)
                    begin
                        expp_next = 1'b0;
                        ov_next = 1'b1; kind_next = EV_START;
                        phase_next = PH_KEY_LEN;
                    end
                    else fmt_next = 1'b1;
                end
                PH_EXPIRY:
                begin
                    exp_next = {b, exp_reg[63:8]};
                    lleft_next = (lleft_reg != 4'd0) ? lleft_reg - 4'd1 : 4'd0;
                    if (lleft_reg <= 4'd1)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (b == TYPE_STR)
                    begin
                        ov_next = 1'b1; kind_next = EV_START;
                        hx_next = expp_reg; em_next = expp_reg ? exp_reg : 64'd0;
                        phase_next = PH_KEY_LEN;
                    end
                    else fmt_next = 1'b1;
                end
                PH_AUXK_STR, PH_AUXV_STR, PH_KEY_STR, PH_VAL_STR:
                begin
                    if (phase_reg == PH_KEY_STR)
                    begin
                        ov_next = 1'b1; kind_next = EV_KEY; ob_next = b;
                    end
                    else if (phase_reg == PH_VAL_STR)
                    begin
                        ov_next = 1'b1; kind_next = EV_VALUE; ob_next = b;
                    end
                    sleft_next = (sleft_reg != 64'd0) ? sleft_reg - 64'd1 : 64'd0;
                    if (sleft_reg <= 64'd1)
                    begin
                        if (phase_reg == PH_AUXK_STR) phase_next = PH_AUXV_LEN;
                        else if (phase_reg == PH_KEY_STR) phase_next = PH_VAL_LEN;
                        else
                        begin
                            if (phase_reg == PH_VAL_STR) pend_next = 1'b1;
                            phase_next = PH_OP;
                        end
                    end
                end
                default:
                begin
                    if (lleft_reg == 4'd0)
                    begin
                        if ((b & LEN_MASK) == LEN_6BIT)
                        begin
                            ld_en = 1'b1; ld_len = {56'd0, b & LEN_LOW};
                        end
                        else if ((b & LEN_MASK) == LEN_14BIT)
                        begin
                            lacc_next = {56'd0, b & LEN_LOW}; lleft_next = 4'd1;
                        end
                        else if (b == LEN_32BIT)
                        begin
                            lacc_next = 64'd0; lleft_next = 4'd4;
                        end
                        else if (b == LEN_64BIT)
                        begin
                            lacc_next = 64'd0; lleft_next = 4'd8;
                        end
                        else fmt_next = 1'b1;
                    end
                    else
                    begin
                        lacc_next = {lacc_reg[55:0], b};
                        lleft_next = lleft_reg - 4'd1;
                        if (lleft_reg == 4'd1)
                        begin
                            ld_en = 1'b1; ld_len = lacc_next;
                        end
                    end
                end
            endcase
        end

        // Length complete: pick the phase that follows the prefix.
        if (ld_en)
        begin
            unique case (phase_reg)
                PH_AUXK_LEN:
                begin
                    sleft_next = ld_len;
                    phase_next = (ld_len != 64'd0) ? PH_AUXK_STR : PH_AUXV_LEN;
                end
                PH_AUXV_LEN:
                begin
                    sleft_next = ld_len;
                    phase_next = (ld_len != 64'd0) ? PH_AUXV_STR : PH_OP;
                end
                PH_RSZ1_LEN: phase_next = PH_RSZ2_LEN;
                PH_KEY_LEN:
                begin
                    sleft_next = ld_len;
                    phase_next = (ld_len != 64'd0) ? PH_KEY_STR : PH_VAL_LEN;
                end
                PH_VAL_LEN:
                begin
                    sleft_next = ld_len;
                    if (ld_len != 64'd0) phase_next = PH_VAL_STR;
                    else
                    begin
                        ov_next = 1'b1; kind_next = EV_END; phase_next = PH_OP;
                    end
                end
                default: phase_next = PH_OP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; hdr_reg <= 4'd0; lacc_reg <= 64'd0;
            lleft_reg <= 4'd0; sleft_reg <= 64'd0; exp_reg <= 64'd0;
            expp_reg <= 1'b0; fmt_reg <= 1'b0; eof_reg <= 1'b0;
            pend_reg <= 1'b0; drn_reg <= 1'b0; didx_reg <= 4'd0;
            dshort_reg <= 1'b0; dcrc_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; hdr_reg <= hdr_next; lacc_reg <= lacc_next;
            lleft_reg <= lleft_next; sleft_reg <= sleft_next; exp_reg <= exp_next;
            expp_reg <= expp_next; fmt_reg <= fmt_next; eof_reg <= eof_next;
            pend_reg <= pend_next; drn_reg <= drn_next; didx_reg <= didx_next;
            dshort_reg <= dshort_next; dcrc_reg <= dcrc_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dwin_reg <= dwin_next;
        if (step)
        begin
            kind_reg <= kind_next; ob_reg <= ob_next; hx_reg <= hx_next;
            em_reg <= em_next; st_reg <= st_next; last_reg <= last_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/snapshot_record_parser_core.sv =====
// Top level of the snapshot record parser.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_ready, in_byte, final_byte     | in
//  output  | out_valid, out_ready, event_kind, out_byte, | out
//          | has_expiry, expiry_ms, status, last_result  |
//
// An item is taken every cycle while the four-entry queue has room; the
// front end (window shift and one unrolled byte of CRC) sets that pace.
// The parser retires one queue entry per cycle while the output is not
// stalled; a value byte that closes its entry adds a separate end event, and
// the last item of a file adds a checksum drain and a status item.
// Reset is asynchronous and clears all control state; no clearing pass.
// A stalled output holds the parser; the queue lets the input run on.
`default_nettype none
module snapshot_record_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_kind,
    output logic [7:0]       out_byte,
    output logic             has_expiry,
    output logic [63:0]      expiry_ms,
    output logic [1:0]       status,
    output logic             last_result
);
    import srp_pkg::*;

    srp_token_t push_token, head;
    logic       push, pop, q_valid, q_room;

    // Take an item whenever the queue can hold what it may produce.
    assign in_ready = q_room;

    srp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_valid && in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .token      (push_token),
        .push       (push)
    );

    srp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .head       (head),
        .not_empty  (q_valid),
        .not_full   (q_room)
    );

    srp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (q_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .out_byte    (out_byte),
        .has_expiry  (has_expiry),
        .expiry_ms   (expiry_ms),
        .status      (status),
        .last_result (last_result)
    );
endmodule
`default_nettype wire

// ===== design/srp_checker.sv =====
// Port-level checker for the snapshot record parser, bound to the top level.
`default_nettype none
module srp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  event_kind,
    input wire logic [7:0]  out_byte,
    input wire logic [1:0]  status,
    input wire logic        last_result
);
    import srp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(out_byte))
        else $error("output item changed while stalled");

    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> event_kind == EV_FINAL)
        else $error("last flag on a non-status item");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_FINAL |-> last_result)
        else $error("status item without last flag");

    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_FINAL |-> status == ST_OK)
        else $error("status set on a data item");
endmodule

bind snapshot_record_parser_core srp_checker u_srp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .out_byte    (out_byte),
    .status      (status),
    .last_result (last_result)
);
`default_nettype wire
